>>> src/tmb_pkg.sv
// ----------------------------------------------------------------------------
// tmb_pkg
// Shared types, constants and address helpers for the tile map blitter.
// ----------------------------------------------------------------------------
package tmb_pkg;

  localparam int MAP_WIDTH   = 64;
  localparam int MAP_HEIGHT  = 64;
  localparam int CHUNK_SIDE  = 32;
  localparam int PAGE_COUNT  = 2;
  localparam int LAYER_COUNT = 2;

  localparam int X_W      = $clog2(MAP_WIDTH);
  localparam int Y_W      = $clog2(MAP_HEIGHT);
  localparam int CHUNK_W  = $clog2(CHUNK_SIDE);
  localparam int PAGE_W   = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int LAYER_W  = (LAYER_COUNT > 1) ? $clog2(LAYER_COUNT) : 1;
  localparam int OFS_W    = X_W + Y_W;
  localparam int ADDR_W   = PAGE_W + LAYER_W + OFS_W;
  localparam int STORE_WORDS = 1 << ADDR_W;
  localparam int WORD_W   = 16;

  localparam logic [2:0] ACT_PUT   = 3'd0;
  localparam logic [2:0] ACT_FILL  = 3'd1;
  localparam logic [2:0] ACT_READ  = 3'd2;
  localparam logic [2:0] ACT_COPY  = 3'd3;
  localparam logic [2:0] ACT_CLEAR = 3'd4;

  localparam logic [2:0] OP_NONE = 3'd0;
  localparam logic [2:0] OP_PUT  = 3'd1;
  localparam logic [2:0] OP_READ = 3'd2;
  localparam logic [2:0] OP_FILL = 3'd3;
  localparam logic [2:0] OP_CRD  = 3'd4;
  localparam logic [2:0] OP_CWR  = 3'd5;
  localparam logic [2:0] OP_CLR  = 3'd6;

  typedef logic [X_W-1:0]    x_t;
  typedef logic [Y_W-1:0]    y_t;
  typedef logic [ADDR_W-1:0] addr_t;

  typedef struct packed {
    logic [2:0]         action;
    logic               layer;
    logic               all_layers;
    logic signed [15:0] x_first;
    logic signed [15:0] y_first;
    logic signed [15:0] x_second;
    logic signed [15:0] y_second;
    logic signed [15:0] x_dest;
    logic signed [15:0] y_dest;
    logic [15:0]        tile_word;
  } in_item_t;

  typedef struct packed {
    logic [15:0] read_word;
    logic [9:0]  char_index;
    logic [3:0]  palette;
    logic        flip_h;
    logic        flip_v;
  } out_item_t;

  typedef struct packed {
    logic       load;
    logic [2:0] op;
    logic       capture;
  } cmd_t;

  typedef struct packed {
    logic rect_last;
    logic clr_last;
  } status_t;

  function automatic x_t clamp_x(logic signed [15:0] v);
    x_t r;
    if (v < 0) begin
      r = '0;
    end else if (v > 16'(MAP_WIDTH - 1)) begin
      r = x_t'(MAP_WIDTH - 1);
    end else begin
      r = v[X_W-1:0];
    end
    return r;
  endfunction

  function automatic y_t clamp_y(logic signed [15:0] v);
    y_t r;
    if (v < 0) begin
      r = '0;
    end else if (v > 16'(MAP_HEIGHT - 1)) begin
      r = y_t'(MAP_HEIGHT - 1);
    end else begin
      r = v[Y_W-1:0];
    end
    return r;
  endfunction

  // chunk row, chunk column, row in chunk, column in chunk
  function automatic addr_t tile_addr(logic [PAGE_W-1:0] page, logic [LAYER_W-1:0] layer,
                                      x_t x, y_t y);
    return {page, layer, y[Y_W-1:CHUNK_W], x[X_W-1:CHUNK_W],
            y[CHUNK_W-1:0], x[CHUNK_W-1:0]};
  endfunction

endpackage

>>> src/tmb_datapath.sv
// ----------------------------------------------------------------------------
// tmb_datapath
// Tile store, corner clamping, rectangle walk counters and result register.
// ----------------------------------------------------------------------------
module tmb_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  tmb_pkg::in_item_t   in_data,
  input  logic                cfg_we,
  input  logic                cfg_wdata,
  input  tmb_pkg::cmd_t       cmd,
  output tmb_pkg::status_t    status,
  output tmb_pkg::out_item_t  out_data
);
  import tmb_pkg::*;

  logic [WORD_W-1:0] mem [STORE_WORDS];

  logic               active_page_r;
  logic [PAGE_W-1:0]  page_r;
  logic [LAYER_W-1:0] layer_r;
  x_t                 x_lo_r, w_r, x_dst_r, ox_r, ox_nxt;
  y_t                 y_lo_r, h_r, y_dst_r, oy_r, oy_nxt;
  logic [WORD_W-1:0]  word_r, rd_data_r, out_word_r;
  logic               fwd_r;
  addr_t              clr_r, clr_end_r;

  x_t    xa, xb, x_lo, x_hi, xd, x_base;
  y_t    ya, yb, y_lo, y_hi, yd, y_base;
  logic  pt_mode, fwd_copy;
  logic [PAGE_W-1:0]  pg;
  logic [LAYER_W-1:0] ly;
  addr_t clr_start, clr_end;
  addr_t addr;
  logic  we, re;
  logic [WORD_W-1:0] wdata;

  always_comb begin
    pg = PAGE_W'(active_page_r % PAGE_COUNT);
    ly = LAYER_W'(in_data.layer % LAYER_COUNT);
    xa = clamp_x(in_data.x_first);
    xb = clamp_x(in_data.x_second);
    ya = clamp_y(in_data.y_first);
    yb = clamp_y(in_data.y_second);
    x_lo = (xa > xb) ? xb : xa;
    x_hi = (xa > xb) ? xa : xb;
    y_lo = (ya > yb) ? yb : ya;
    y_hi = (ya > yb) ? ya : yb;
    xd = clamp_x(in_data.x_dest);
    yd = clamp_y(in_data.y_dest);
    pt_mode = (in_data.action == ACT_PUT) || (in_data.action == ACT_READ);
    fwd_copy = (yd < y_lo) || ((yd == y_lo) && (xd < x_lo));
    x_base = pt_mode ? in_data.x_first[X_W-1:0] : x_lo;
    y_base = pt_mode ? in_data.y_first[Y_W-1:0] : y_lo;
    if (in_data.all_layers) begin
      clr_start = {pg, {LAYER_W{1'b0}}, {OFS_W{1'b0}}};
      clr_end   = {pg, {LAYER_W{1'b1}}, {OFS_W{1'b1}}};
    end else begin
      clr_start = {pg, ly, {OFS_W{1'b0}}};
      clr_end   = {pg, ly, {OFS_W{1'b1}}};
    end
  end

  // rectangle walk: raster order forward, reverse raster backward
  always_comb begin
    if (fwd_r) begin
      status.rect_last = (ox_r == w_r) && (oy_r == h_r);
      if (ox_r == w_r) begin
        ox_nxt = '0;
        oy_nxt = oy_r + y_t'(1);
      end else begin
        ox_nxt = ox_r + x_t'(1);
        oy_nxt = oy_r;
      end
    end else begin
      status.rect_last = (ox_r == '0) && (oy_r == '0);
      if (ox_r == '0) begin
        ox_nxt = w_r;
        oy_nxt = oy_r - y_t'(1);
      end else begin
        ox_nxt = ox_r - x_t'(1);
        oy_nxt = oy_r;
      end
    end
    status.clr_last = (clr_r == clr_end_r);
  end

  always_comb begin
    addr  = clr_r;
    we    = 1'b0;
    re    = 1'b0;
    wdata = '0;
    unique case (cmd.op)
      OP_PUT: begin
        addr  = tile_addr(page_r, layer_r, x_lo_r, y_lo_r);
        we    = 1'b1;
        wdata = word_r;
      end
      OP_READ: begin
        addr = tile_addr(page_r, layer_r, x_lo_r, y_lo_r);
        re   = 1'b1;
      end
      OP_FILL: begin
        addr  = tile_addr(page_r, layer_r, x_lo_r + ox_r, y_lo_r + oy_r);
        we    = 1'b1;
        wdata = word_r;
      end
      OP_CRD: begin
        addr = tile_addr(page_r, layer_r, x_lo_r + ox_r, y_lo_r + oy_r);
        re   = 1'b1;
      end
      OP_CWR: begin
        // destination wraps modulo the map
        addr  = tile_addr(page_r, layer_r, x_dst_r + ox_r, y_dst_r + oy_r);
        we    = 1'b1;
        wdata = rd_data_r;
      end
      OP_CLR: begin
        addr  = clr_r;
        we    = 1'b1;
        wdata = '0;
      end
      default: begin
        addr = clr_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rd_data_r <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_page_r <= 1'b0;
      clr_r         <= '0;
      clr_end_r     <= '1;
    end else begin
      if (cfg_we) begin
        active_page_r <= cfg_wdata;
      end
      if (cmd.load) begin
        clr_r     <= clr_start;
        clr_end_r <= clr_end;
      end else if (cmd.op == OP_CLR) begin
        clr_r <= clr_r + addr_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      page_r     <= pg;
      layer_r    <= ly;
      x_lo_r     <= x_base;
      y_lo_r     <= y_base;
      w_r        <= x_hi - x_lo;
      h_r        <= y_hi - y_lo;
      x_dst_r    <= xd;
      y_dst_r    <= yd;
      word_r     <= in_data.tile_word;
      fwd_r      <= (in_data.action != ACT_COPY) || fwd_copy;
      out_word_r <= '0;
      if ((in_data.action != ACT_COPY) || fwd_copy) begin
        ox_r <= '0;
        oy_r <= '0;
      end else begin
        ox_r <= x_hi - x_lo;
        oy_r <= y_hi - y_lo;
      end
    end else begin
      if ((cmd.op == OP_FILL) || (cmd.op == OP_CWR)) begin
        ox_r <= ox_nxt;
        oy_r <= oy_nxt;
      end
      if (cmd.capture) begin
        out_word_r <= rd_data_r;
      end
    end
  end

  always_comb begin
    out_data.read_word  = out_word_r;
    out_data.char_index = out_word_r[9:0];
    out_data.palette    = out_word_r[15:12];
    out_data.flip_h     = out_word_r[10];
    out_data.flip_v     = out_word_r[11];
  end

endmodule

>>> src/tmb_ctrl.sv
// ----------------------------------------------------------------------------
// tmb_ctrl
// Command sequencer: decodes the action and steps the datapath per tile.
// ----------------------------------------------------------------------------
module tmb_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [2:0]       in_action,
  input  tmb_pkg::status_t status,
  output tmb_pkg::cmd_t    cmd,
  output logic             busy,
  output logic             done
);
  import tmb_pkg::*;

  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_PUT   = 4'd2;
  localparam logic [3:0] S_READ  = 4'd3;
  localparam logic [3:0] S_RWAIT = 4'd4;
  localparam logic [3:0] S_FILL  = 4'd5;
  localparam logic [3:0] S_CRD   = 4'd6;
  localparam logic [3:0] S_CWR   = 4'd7;
  localparam logic [3:0] S_CLR   = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  logic [3:0] state_r, state_nxt;

  always_comb begin
    state_nxt   = state_r;
    cmd.load    = 1'b0;
    cmd.op      = OP_NONE;
    cmd.capture = 1'b0;
    unique case (state_r)
      S_INIT: begin
        cmd.op = OP_CLR;
        if (status.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          unique case (in_action)
            ACT_PUT:   state_nxt = S_PUT;
            ACT_READ:  state_nxt = S_READ;
            ACT_FILL:  state_nxt = S_FILL;
            ACT_COPY:  state_nxt = S_CRD;
            ACT_CLEAR: state_nxt = S_CLR;
            default:   state_nxt = S_DONE;
          endcase
        end
      end
      S_PUT: begin
        cmd.op    = OP_PUT;
        state_nxt = S_DONE;
      end
      S_READ: begin
        cmd.op    = OP_READ;
        state_nxt = S_RWAIT;
      end
      S_RWAIT: begin
        cmd.capture = 1'b1;
        state_nxt   = S_DONE;
      end
      S_FILL: begin
        cmd.op = OP_FILL;
        if (status.rect_last) begin
          state_nxt = S_DONE;
        end
      end
      S_CRD: begin
        cmd.op    = OP_CRD;
        state_nxt = S_CWR;
      end
      S_CWR: begin
        cmd.op    = OP_CWR;
        state_nxt = status.rect_last ? S_DONE : S_CRD;
      end
      S_CLR: begin
        cmd.op = OP_CLR;
        if (status.clr_last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);
  assign done = (state_r == S_DONE);

endmodule

>>> src/tile_map_blit_engine.sv
// ----------------------------------------------------------------------------
// tile_map_blit_engine
// Put, fill, read, copy and clear of 16-bit tiles on a paged, layered map.
// ----------------------------------------------------------------------------
// After reset the engine zeroes the whole 16384-word tile store, one word per
// cycle, and holds busy high until it is done; configuration writes are taken
// meanwhile. A transaction is taken when start is high and busy is low.
// The single-port tile store does one access per cycle: put writes the tile,
// read reads it and then captures the word, fill writes each tile of the
// rectangle, copy reads then writes each tile, and clear zeroes one layer or
// both. out_valid is high for one cycle and the receiver cannot stall it;
// busy drops the cycle after.
// ----------------------------------------------------------------------------
module tile_map_blit_engine (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  tmb_pkg::in_item_t   in_data,
  output logic                out_valid,
  output tmb_pkg::out_item_t  out_data,
  input  logic                cfg_we,
  input  logic                cfg_wdata
);
  import tmb_pkg::*;

  cmd_t    cmd;
  status_t status;

  tmb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_action (in_data.action),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy),
    .done      (out_valid)
  );

  tmb_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_data)
  );

  a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result strobe outside a transaction");

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> (!out_valid && !busy))
    else $error("result strobe longer than one cycle");

  a_no_load_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> !busy)
    else $error("transaction loaded while busy");

endmodule
